// File: hw/rtl/dmf_pkg.sv
// Package for the demo message framer: payload types, register indexes and constants.
`timescale 1ns / 1ps
package dmf_pkg;

	// Buffer limit; bytes beyond it are dropped, only the last mark still counts
	localparam int unsigned MAX_BUFFER_BYTES = 65536;
	localparam int unsigned BYTES_W          = $clog2(MAX_BUFFER_BYTES + 1);

	// Message layout constants
	localparam logic [3:0]  SET_TOTAL_LEN  = 4'd10;
	localparam logic [3:0]  MULTI_LEN_OFS  = 4'd6;
	localparam logic [3:0]  OTHER_LEN_OFS  = 4'd2;
	localparam logic [3:0]  HP_PAYLOAD     = 4'd15;
	localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
	localparam logic [23:0] TIME_MAX       = 24'hFFFFFF;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TYPE_MASK  = 2'd0,
		REG_SET_CODE   = 2'd1,
		REG_MULTI_CODE = 2'd2
	} cfg_reg_t;

	// Kind of the message in progress
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_MULTI = 2'd2,
		KIND_OTHER = 2'd3
	} msg_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [16:0] complete_bytes;
		logic [23:0] time_total;
	} out_item_t;

endpackage

// File: hw/rtl/demo_message_framer.sv
// Demo message framer: frames a byte stream of demo messages and reports whole-message totals.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | sink      | in_valid / in_ready   | in_data  (data_byte, last_byte)
//  out     | source    | out_valid / out_ready | out_data (complete_bytes, time_total)
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One byte per cycle sustained unless a result stalls: a byte is captured in the input
// register, framed by the combinational next-state logic, and on the last byte the
// totals land in the output register when that staged byte moves on.
// The longest path is the 33-bit length add and saturating count compare.
// Reset clears all framing state and loads the register defaults; no clearing pass.
// A stalled result only holds back a following last byte; other bytes keep flowing.
`timescale 1ns / 1ps
module demo_message_framer
	import dmf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	// Configuration registers
	logic [7:0] type_mask_q, set_code_q, multi_code_q;

	// Input register
	logic       valid_s1;
	in_item_t   item_s1;

	// Framing state
	logic [3:0]         hp_q, hp_d;
	msg_kind_t          kind_q, kind_d;
	logic [31:0]        len_q, len_d;
	logic [31:0]        left_q, left_d;
	logic [7:0]         ptime_q, ptime_d;
	logic [16:0]        count_q, count_d;
	logic [23:0]        tsum_q, tsum_d;
	logic [BYTES_W-1:0] seen_q, seen_d;

	// Output register
	logic      out_valid_q;
	out_item_t out_item_q;

	logic       advance;
	logic       take;
	logic       finish;
	logic [7:0] masked;
	logic [3:0] ofs;
	logic [1:0] lane;
	logic [32:0] total;
	logic [33:0] count_sum;
	logic [24:0] time_sum_w;
	logic [16:0] count_fin;
	logic [23:0] tsum_fin;

	assign cfg_ready = 1'b1;

	// Configuration writes; unlisted indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_mask_q  <= 8'd7;
			set_code_q   <= 8'd2;
			multi_code_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TYPE_MASK:  type_mask_q  <= cfg_data;
				REG_SET_CODE:   set_code_q   <= cfg_data;
				REG_MULTI_CODE: multi_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The staged byte moves on unless it is a last byte and the result slot is full
	assign advance  = valid_s1 && (!item_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Message totals used when a message completes
	always_comb begin
		case (kind_q)
			KIND_SET:   total = 33'(SET_TOTAL_LEN);
			KIND_MULTI: total = {1'b0, len_q} + 33'(MULTI_LEN_OFS) + 33'd4;
			default:    total = {1'b0, len_q} + 33'(OTHER_LEN_OFS) + 33'd4;
		endcase
		count_sum  = {17'd0, count_q} + {1'b0, total};
		time_sum_w = {1'b0, tsum_q} + {17'd0, ptime_q};
		count_fin  = (count_sum > 34'(COUNT_MAX)) ? COUNT_MAX : count_sum[16:0];
		tsum_fin   = (time_sum_w > 25'(TIME_MAX)) ? TIME_MAX : time_sum_w[23:0];
	end

	assign masked = item_s1.data_byte & type_mask_q;
	assign ofs    = (kind_q == KIND_MULTI) ? MULTI_LEN_OFS : OTHER_LEN_OFS;
	assign lane   = hp_q[1:0] - ofs[1:0];
	assign take   = advance && (seen_q < BYTES_W'(MAX_BUFFER_BYTES));

	// Next framing state for the staged byte
	always_comb begin
		hp_d    = hp_q;
		kind_d  = kind_q;
		len_d   = len_q;
		left_d  = left_q;
		ptime_d = ptime_q;
		count_d = count_q;
		tsum_d  = tsum_q;
		seen_d  = seen_q;
		finish  = 1'b0;
		if (take) begin
			seen_d = seen_q + BYTES_W'(1);
			case (hp_q)
				4'd0: begin
					ptime_d = item_s1.data_byte;
					hp_d    = 4'd1;
				end
				4'd1: begin
					if (masked == set_code_q) begin
						kind_d = KIND_SET;
						left_d = 32'(SET_TOTAL_LEN) - 32'd2;
						hp_d   = HP_PAYLOAD;
					end else begin
						kind_d = (masked == multi_code_q) ? KIND_MULTI : KIND_OTHER;
						hp_d   = 4'd2;
					end
				end
				HP_PAYLOAD: begin
					left_d = left_q - 32'd1;
					finish = (left_q == 32'd1);
				end
				default: begin
					// Length field bytes, little-endian
					if (hp_q >= ofs) begin
						len_d = len_q | ({24'd0, item_s1.data_byte} << {lane, 3'b000});
					end
					if (hp_q == ofs + 4'd3) begin
						if (len_d == 32'd0) begin
							finish = 1'b1;
						end else begin
							left_d = len_d;
							hp_d   = HP_PAYLOAD;
						end
					end else begin
						hp_d = hp_q + 4'd1;
					end
				end
			endcase
		end
		if (finish) begin
			count_d = count_fin;
			tsum_d  = tsum_fin;
			hp_d    = 4'd0;
			kind_d  = KIND_NONE;
			len_d   = 32'd0;
			left_d  = 32'd0;
		end
	end

	// Framing state; a last byte reports and clears for the next buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q    <= 4'd0;
			kind_q  <= KIND_NONE;
			len_q   <= 32'd0;
			left_q  <= 32'd0;
			ptime_q <= 8'd0;
			count_q <= 17'd0;
			tsum_q  <= 24'd0;
			seen_q  <= '0;
		end else if (advance && item_s1.last_byte) begin
			hp_q    <= 4'd0;
			kind_q  <= KIND_NONE;
			len_q   <= 32'd0;
			left_q  <= 32'd0;
			ptime_q <= 8'd0;
			count_q <= 17'd0;
			tsum_q  <= 24'd0;
			seen_q  <= '0;
		end else begin
			hp_q    <= hp_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			left_q  <= left_d;
			ptime_q <= ptime_d;
			count_q <= count_d;
			tsum_q  <= tsum_d;
			seen_q  <= seen_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			out_item_q.complete_bytes <= count_d;
			out_item_q.time_total     <= tsum_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

	// Checks on the framing logic
	a_hp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hp_q <= 4'd9) || (hp_q == HP_PAYLOAD))
		else $error("header position outside the message layout");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(hp_q == HP_PAYLOAD) |-> (left_q != 32'd0))
		else $error("payload state with nothing left to take");

	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		(hp_q >= 4'd2) |-> (kind_q != KIND_NONE))
		else $error("past the type byte without a message kind");

	a_kind_none: assert property (@(posedge clk) disable iff (!arst_n)
		(hp_q <= 4'd1) |-> (kind_q == KIND_NONE))
		else $error("message kind set before the type byte");

	a_seen_limit: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= BYTES_W'(MAX_BUFFER_BYTES))
		else $error("byte count beyond the buffer limit");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(valid_s1 && item_s1.last_byte))
		else $error("result raised without a last byte");

endmodule

// File: verif/tb_demo_message_framer.sv
// Self-checking testbench for the demo message framer: directed table, then random buffers.
`timescale 1ns / 1ps
module tb_demo_message_framer;
	import dmf_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned PHASE_BYTES   = 170;
	localparam int unsigned REPORT_MAX    = 10;
	// Unmapped register index, a write to it must change nothing
	localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

	// Directed row: one byte, plus a hand-typed expectation where the totals are obvious
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic        typed;
		logic [16:0] bytes_want;
		logic [23:0] time_want;
	} dir_row_t;

	// Reset register values: mask 7, set code 2, multiple code 3
	localparam dir_row_t DIR_TABLE [23] = '{
		// lone last byte straight after reset: nothing complete
		'{8'h00, 1'b1, 1'b1, 17'd0, 24'd0},
		// set message, type 0xFA masks to the set code, time 0xFF
		'{8'hFF, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'hFA, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'hFF, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h55, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'hAA, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h01, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h80, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h7F, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'hFE, 1'b1, 1'b1, 17'd10, 24'd255},
		// other kind with zero stored length, then one stray byte left partial
		'{8'h80, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h11, 1'b1, 1'b1, 17'd6, 24'd128},
		// multiple kind cut short inside its header
		'{8'h01, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h0B, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'hAA, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h55, 1'b0, 1'b0, 17'd0, 24'd0},
		'{8'h33, 1'b1, 1'b1, 17'd0, 24'd0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;

	// Typed expectation travelling with the byte on the input channel
	logic        row_typed = 1'b0;
	out_item_t   row_want  = '0;

	// Register mirror
	logic [7:0]  type_mask_q  = 8'd7;
	logic [7:0]  set_code_q   = 8'd2;
	logic [7:0]  multi_code_q = 8'd3;

	// Framing state mirror
	logic [3:0]  hdr_pos;
	msg_kind_t   cur_kind;
	logic [31:0] len_acc;
	logic [31:0] body_left;
	logic [7:0]  held_time;
	logic [16:0] done_bytes;
	logic [23:0] time_acc;
	int unsigned bytes_taken;

	out_item_t   totals_q [$];
	int unsigned bad_results = 0;
	logic [7:0]  buf_q [$];
	bit          rx_pace = 1'b1;

	demo_message_framer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Framing state back to the start of a buffer
	function automatic void clear_stream();
		hdr_pos     = 4'd0;
		cur_kind    = KIND_NONE;
		len_acc     = '0;
		body_left   = '0;
		held_time   = '0;
		done_bytes  = '0;
		time_acc    = '0;
		bytes_taken = 0;
	endfunction

	// Message complete: add its length and time byte, saturating
	function automatic void close_message();
		logic [63:0] total;
		logic [63:0] sum;
		if (cur_kind == KIND_SET)
			total = 64'(SET_TOTAL_LEN);
		else if (cur_kind == KIND_MULTI)
			total = 64'(len_acc) + 64'(MULTI_LEN_OFS) + 64'd4;
		else
			total = 64'(len_acc) + 64'(OTHER_LEN_OFS) + 64'd4;
		sum = 64'(done_bytes) + total;
		done_bytes = (sum > 64'(COUNT_MAX)) ? COUNT_MAX : sum[16:0];
		sum = 64'(time_acc) + 64'(held_time);
		time_acc = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[23:0];
		hdr_pos   = 4'd0;
		cur_kind  = KIND_NONE;
		len_acc   = '0;
		body_left = '0;
	endfunction

	// Advance the framer by one byte; returns 1 with the totals on a last byte
	function automatic bit frame_byte(input in_item_t it, output out_item_t totals);
		logic [7:0] b;
		logic [7:0] m;
		logic [3:0] ofs;
		b = it.data_byte;
		totals = '0;
		if (bytes_taken < MAX_BUFFER_BYTES) begin
			bytes_taken++;
			if (hdr_pos == 4'd0) begin
				held_time = b;
				hdr_pos = 4'd1;
			end else if (hdr_pos == 4'd1) begin
				m = b & type_mask_q;
				if (m == set_code_q) begin
					cur_kind  = KIND_SET;
					body_left = 32'(SET_TOTAL_LEN) - 32'd2;
					hdr_pos   = HP_PAYLOAD;
				end else begin
					cur_kind = (m == multi_code_q) ? KIND_MULTI : KIND_OTHER;
					hdr_pos  = 4'd2;
				end
			end else if (hdr_pos == HP_PAYLOAD) begin
				body_left--;
				if (body_left == 0)
					close_message();
			end else begin
				ofs = (cur_kind == KIND_MULTI) ? MULTI_LEN_OFS : OTHER_LEN_OFS;
				if (hdr_pos >= ofs)
					len_acc |= 32'(b) << (int'(hdr_pos - ofs) * 8);
				if (hdr_pos == ofs + 4'd3) begin
					if (len_acc == 0) begin
						close_message();
					end else begin
						body_left = len_acc;
						hdr_pos   = HP_PAYLOAD;
					end
				end else begin
					hdr_pos = hdr_pos + 4'd1;
				end
			end
		end
		if (!it.last_byte)
			return 1'b0;
		totals.complete_bytes = done_bytes;
		totals.time_total     = time_acc;
		clear_stream();
		return 1'b1;
	endfunction

	initial clear_stream();

	// Transfer monitor: results checked first, then accepted bytes and register writes
	always @(posedge clk) begin
		out_item_t totals;
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (totals_q.size() == 0) begin
					if (bad_results < REPORT_MAX)
						$display("unexpected result: bytes %0d time %0d",
							out_data.complete_bytes, out_data.time_total);
					bad_results++;
				end else begin
					want = totals_q.pop_front();
					if (out_data.complete_bytes != want.complete_bytes ||
							out_data.time_total != want.time_total) begin
						if (bad_results < REPORT_MAX)
							$display("result wrong: bytes exp %0d got %0d, time exp %0d got %0d",
								want.complete_bytes, out_data.complete_bytes,
								want.time_total, out_data.time_total);
						bad_results++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (frame_byte(in_data, totals))
					totals_q.push_back(row_typed ? row_want : totals);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TYPE_MASK:  type_mask_q  = cfg_data;
					REG_SET_CODE:   set_code_q   = cfg_data;
					REG_MULTI_CODE: multi_code_q = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Result side: random stall before each transfer while rx_pace is set
	initial begin
		int unsigned stall;
		forever begin
			stall = rx_pace ? $urandom_range(0, 12) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Run limit
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, totals_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One byte transfer, optionally preceded by an idle gap
	task automatic send_byte(input in_item_t it, input bit pace, input bit typed,
			input out_item_t want);
		int unsigned gap;
		gap = pace ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		in_data   <= it;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_buffer(input bit pace);
		in_item_t it;
		for (int i = 0; i < buf_q.size(); i++) begin
			it.data_byte = buf_q[i];
			it.last_byte = (i == buf_q.size() - 1);
			send_byte(it, pace, 1'b0, '0);
		end
	endtask

	// Stop sending, wait for every result, then let the pipeline empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (totals_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] mask, input logic [7:0] set_code,
			input logic [7:0] multi_code);
		write_reg(REG_UNMAPPED, 8'($urandom));
		write_reg(REG_TYPE_MASK, mask);
		write_reg(REG_SET_CODE, set_code);
		write_reg(REG_MULTI_CODE, multi_code);
	endtask

	// Append one message under the current register values; a huge length is left without its body
	task automatic add_message(input bit allow_huge);
		logic [7:0]  code;
		logic [7:0]  kbyte;
		logic [7:0]  m;
		logic [31:0] len;
		int unsigned n_body;
		case ($urandom_range(0, 2))
			0:       code = set_code_q;
			1:       code = multi_code_q;
			default: code = 8'($urandom);
		endcase
		kbyte = (code & type_mask_q) | (8'($urandom) & ~type_mask_q);
		m = kbyte & type_mask_q;
		buf_q.push_back(8'($urandom));
		buf_q.push_back(kbyte);
		if (m == set_code_q) begin
			n_body = 32'(SET_TOTAL_LEN - 4'd2);
		end else begin
			if (m == multi_code_q)
				repeat (MULTI_LEN_OFS - OTHER_LEN_OFS) buf_q.push_back(8'($urandom));
			case ($urandom_range(0, 15))
				0, 1:    len = 32'd0;
				// huge length: the rest of the buffer becomes its body
				2:       len = allow_huge ? 32'($urandom) : 32'd0;
				default: len = $urandom_range(1, 24);
			endcase
			for (int i = 0; i < 4; i++)
				buf_q.push_back(len[8*i +: 8]);
			n_body = (len > 32'd64) ? 0 : len;
		end
		repeat (n_body) buf_q.push_back(8'($urandom));
	endtask

	// Mostly whole messages with an optional broken tail, sometimes pure noise
	task automatic build_buffer();
		buf_q.delete();
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 20)) buf_q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 5)) add_message(1'b1);
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom));
		end
		if (buf_q.size() == 0)
			buf_q.push_back(8'($urandom));
	endtask

	// Main sequence
	initial begin
		in_item_t    it;
		out_item_t   want;
		int unsigned phase_bytes;
		logic [7:0]  rnd_mask;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table under reset register values
		foreach (DIR_TABLE[i]) begin
			it.data_byte        = DIR_TABLE[i].data_byte;
			it.last_byte        = DIR_TABLE[i].last_byte;
			want.complete_bytes = DIR_TABLE[i].bytes_want;
			want.time_total     = DIR_TABLE[i].time_want;
			send_byte(it, 1'b1, DIR_TABLE[i].typed, want);
		end

		// Random buffers across register settings
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			rnd_mask = 8'($urandom);
			case (p)
				0: ;
				1: apply_setting(8'hFF, 8'hFF, 8'h00);
				2: apply_setting(8'h00, 8'h00, 8'h00);
				3: apply_setting(8'h0F, 8'h05, 8'h05);
				4: apply_setting(8'h03, 8'h04, 8'h01);
				7: apply_setting(8'h07, 8'h02, 8'h03);
				default: apply_setting(rnd_mask, 8'($urandom) & rnd_mask,
					8'($urandom) & rnd_mask);
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				build_buffer();
				rx_pace = ($urandom_range(0, 3) != 0);
				send_buffer($urandom_range(0, 3) != 0);
				phase_bytes += buf_q.size();
				// now and then the sender holds off until all totals are back
				if ($urandom_range(0, 5) == 0)
					wait_idle();
			end
		end

		wait_idle();
		if (bad_results == 0 && totals_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/dmf_pkg.sv
hw/rtl/demo_message_framer.sv
verif/tb_demo_message_framer.sv
